>>> src/pec_pkg.sv
// Shared types, constants and helpers for the particle Euler step with box collision.
// Used by every module of the block; depends on nothing.

package pec_pkg;

   typedef logic [31:0] q16_type;
   typedef q16_type [2:0] vec3_type;
   typedef logic [15:0] dt_type;
   typedef logic [16:0] factor_type;

   localparam factor_type Q_ONE   = 17'd65536;
   localparam q16_type    Q16_MAX = 32'h7fff_ffff;
   localparam q16_type    Q16_MIN = 32'h8000_0000;

   localparam logic [2:0] AXIS_X = 3'b001;
   localparam logic [2:0] AXIS_Y = 3'b010;
   localparam logic [2:0] AXIS_Z = 3'b100;

   typedef enum logic [2:0] {
      CSR_LOWER_X,
      CSR_LOWER_Y,
      CSR_LOWER_Z,
      CSR_UPPER_X,
      CSR_UPPER_Y,
      CSR_UPPER_Z,
      CSR_BOUNCE,
      CSR_DRAG
   } csr_index_type;

   typedef struct packed {
      dt_type   dt;
      vec3_type acc;
      vec3_type vel;
      vec3_type pos;
   } particle_type;

   typedef struct packed {
      vec3_type vel;
      vec3_type pos;
   } motion_type;

   typedef struct packed {
      logic [2:0] lo;
      logic [2:0] hi;
      vec3_type   vel;
      vec3_type   pos;
   } contact_type;

   typedef struct packed {
      vec3_type   lower;
      vec3_type   upper;
      factor_type bounce;
      factor_type tang;
   } box_cfg_type;

   // saturate a 34-bit two's complement value to 32 bits
   function automatic q16_type sat_q16(input logic [33:0] x);
      if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
         return x[31:0];
      end else if (x[33]) begin
         return Q16_MIN;
      end else begin
         return Q16_MAX;
      end
   endfunction

   function automatic factor_type clamp_factor(input factor_type f);
      return (f > Q_ONE) ? Q_ONE : f;
   endfunction

endpackage

>>> src/pec_euler.sv
// Semi-implicit Euler update: v += a*dt, then p += v*dt, over four register stages.
// Depends on pec_pkg.

module pec_euler (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pec_pkg::particle_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pec_pkg::motion_type   out_data
);
   import pec_pkg::*;

   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff;
   logic a_en, b_en, c_en, d_en;

   vec3_type          a_pos_ff, a_vel_ff;
   dt_type            a_dt_ff;
   logic signed [48:0] a_prod_ff [3];
   logic signed [48:0] a_prod_in [3];

   vec3_type b_pos_ff, b_vel_ff, b_vel_in;
   dt_type   b_dt_ff;

   vec3_type          c_pos_ff, c_vel_ff;
   logic signed [48:0] c_prod_ff [3];
   logic signed [48:0] c_prod_in [3];

   vec3_type d_pos_ff, d_pos_in, d_vel_ff;

   // a stage loads when empty or when its content moves on
   assign d_en     = !d_vld_ff || out_ready;
   assign c_en     = !c_vld_ff || d_en;
   assign b_en     = !b_vld_ff || c_en;
   assign a_en     = !a_vld_ff || b_en;
   assign in_ready = a_en;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_prod_in[i] = $signed(in_data.acc[i]) * $signed({1'b0, in_data.dt});
         b_vel_in[i]  = sat_q16({{2{a_vel_ff[i][31]}}, a_vel_ff[i]}
                                + {a_prod_ff[i][48], a_prod_ff[i][48:16]});
         c_prod_in[i] = $signed(b_vel_ff[i]) * $signed({1'b0, b_dt_ff});
         d_pos_in[i]  = sat_q16({{2{c_pos_ff[i][31]}}, c_pos_ff[i]}
                                + {c_prod_ff[i][48], c_prod_ff[i][48:16]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         if (a_en) a_vld_ff <= in_valid;
         if (b_en) b_vld_ff <= a_vld_ff;
         if (c_en) c_vld_ff <= b_vld_ff;
         if (d_en) d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_pos_ff <= in_data.pos;
         a_vel_ff <= in_data.vel;
         a_dt_ff  <= in_data.dt;
         for (int i = 0; i < 3; i++) a_prod_ff[i] <= a_prod_in[i];
      end
      if (b_en) begin
         b_pos_ff <= a_pos_ff;
         b_vel_ff <= b_vel_in;
         b_dt_ff  <= a_dt_ff;
      end
      if (c_en) begin
         c_pos_ff <= b_pos_ff;
         c_vel_ff <= b_vel_ff;
         for (int i = 0; i < 3; i++) c_prod_ff[i] <= c_prod_in[i];
      end
      if (d_en) begin
         d_pos_ff <= d_pos_in;
         d_vel_ff <= c_vel_ff;
      end
   end

   always_comb begin
      out_valid    = d_vld_ff;
      out_data.pos = d_pos_ff;
      out_data.vel = d_vel_ff;
   end

`ifndef SYNTHESIS
   // a zero time step leaves velocity untouched
   assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && b_en && a_dt_ff == '0) |=> (b_vel_ff == $past(a_vel_ff)))
      else $error("velocity changed with zero time step");
`endif

endmodule

>>> src/pec_clamp.sv
// Box test: flag coordinates below lower or above upper and clamp them, one stage.
// Depends on pec_pkg.

module pec_clamp (
   input  logic                  clock,
   input  logic                  reset,
   input  pec_pkg::vec3_type     lower,
   input  pec_pkg::vec3_type     upper,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pec_pkg::motion_type   in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pec_pkg::contact_type  out_data
);
   import pec_pkg::*;

   logic        vld_ff;
   logic        en;
   contact_type data_ff, data_in;

   assign en       = !vld_ff || out_ready;
   assign in_ready = en;

   // lower test wins when the bounds are inverted
   always_comb begin
      data_in.vel = in_data.vel;
      for (int i = 0; i < 3; i++) begin
         data_in.lo[i] = $signed(in_data.pos[i]) < $signed(lower[i]);
         data_in.hi[i] = !data_in.lo[i] && ($signed(in_data.pos[i]) > $signed(upper[i]));
         if (data_in.lo[i]) begin
            data_in.pos[i] = lower[i];
         end else if (data_in.hi[i]) begin
            data_in.pos[i] = upper[i];
         end else begin
            data_in.pos[i] = in_data.pos[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

>>> src/pec_axis.sv
// Collision response for one axis: bounce on the wall axis, drag on the other two.
// Multiply stage then shift and saturate stage. Depends on pec_pkg.

module pec_axis (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            axis_sel,
   input  pec_pkg::factor_type   bounce,
   input  pec_pkg::factor_type   tang,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pec_pkg::contact_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pec_pkg::contact_type  out_data
);
   import pec_pkg::*;

   logic m_vld_ff, n_vld_ff;
   logic m_en, n_en;
   logic hit;

   logic signed [17:0] factor_in [3];
   logic signed [49:0] m_prod_in [3];
   logic signed [49:0] m_prod_ff [3];
   vec3_type           m_pos_ff;
   logic [2:0]         m_lo_ff, m_hi_ff;

   contact_type n_data_ff, n_data_in;

   assign n_en     = !n_vld_ff || out_ready;
   assign m_en     = !m_vld_ff || n_en;
   assign in_ready = m_en;

   assign hit = |((in_data.lo | in_data.hi) & axis_sel);

   // an untouched lane multiplies by one so every lane takes the same path
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (axis_sel[i]) begin
            if ((in_data.lo[i] && in_data.vel[i][31]) ||
                (in_data.hi[i] && !in_data.vel[i][31] && in_data.vel[i] != '0)) begin
               factor_in[i] = -$signed({1'b0, bounce});
            end else begin
               factor_in[i] = $signed({1'b0, Q_ONE});
            end
         end else if (hit) begin
            factor_in[i] = $signed({1'b0, tang});
         end else begin
            factor_in[i] = $signed({1'b0, Q_ONE});
         end
         m_prod_in[i] = $signed(in_data.vel[i]) * factor_in[i];
      end
   end

   always_comb begin
      n_data_in.pos = m_pos_ff;
      n_data_in.lo  = m_lo_ff;
      n_data_in.hi  = m_hi_ff;
      for (int i = 0; i < 3; i++) begin
         n_data_in.vel[i] = sat_q16(m_prod_ff[i][49:16]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         n_vld_ff <= 1'b0;
      end else begin
         if (m_en) m_vld_ff <= in_valid;
         if (n_en) n_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m_en) begin
         m_pos_ff <= in_data.pos;
         m_lo_ff  <= in_data.lo;
         m_hi_ff  <= in_data.hi;
         for (int i = 0; i < 3; i++) m_prod_ff[i] <= m_prod_in[i];
      end
      if (n_en) begin
         n_data_ff <= n_data_in;
      end
   end

   assign out_valid = n_vld_ff;
   assign out_data  = n_data_ff;

`ifndef SYNTHESIS
   // after the response, velocity never points out through the upper wall
   assert property (@(posedge clock) disable iff (reset)
      n_vld_ff |-> ((n_data_ff.hi & axis_sel &
         {!n_data_ff.vel[2][31] && (n_data_ff.vel[2] != '0),
          !n_data_ff.vel[1][31] && (n_data_ff.vel[1] != '0),
          !n_data_ff.vel[0][31] && (n_data_ff.vel[0] != '0)}) == 3'b000))
      else $error("outward velocity left at upper wall");

   // nor out through the lower wall
   assert property (@(posedge clock) disable iff (reset)
      n_vld_ff |-> ((n_data_ff.lo & axis_sel &
         {n_data_ff.vel[2][31], n_data_ff.vel[1][31], n_data_ff.vel[0][31]}) == 3'b000))
      else $error("outward velocity left at lower wall");
`endif

endmodule

>>> src/particle_euler_box_collide.sv
// Top level of the particle Euler step with box collision.
// Depends on pec_pkg, pec_euler, pec_clamp and pec_axis.
//
// Usage:
//   req_* is a stream of particles, one per transaction: position, velocity,
//   acceleration (signed Q16.16 each) and a Q0.16 time step. rsp_* returns one
//   transaction per particle, in order: clamped position, updated velocity and
//   a per-axis hit mask. csr_* loads the box bounds, restitution and friction;
//   write it only while no particle is in flight.
//   From req acceptance to rsp_tvalid a particle passes four Euler stages
//   (two multiply/add pairs), one clamp stage, and a multiply stage plus a
//   saturate stage for each of the x, y and z collision responses.
//   Throughput is one particle per cycle unless rsp_tready stalls; a stage
//   holds one transaction and every multiplier is registered before its add.
//   A stage loads whenever it is empty or its content moves on, so a stalled
//   rsp_tready holds the results in place and req_tready drops only once every
//   stage up to the input is full; bubbles are squeezed out.
//   Reset empties the pipeline and sets the box to the full Q16.16 range,
//   restitution to zero and friction to zero.

module particle_euler_box_collide (
   input  logic         clock,
   input  logic         reset,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, step_time
   input  logic [303:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, hit_mask, zero pad
   output logic [199:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import pec_pkg::*;

   box_cfg_type  cfg_ff;
   particle_type req_data;
   motion_type   eul_data;
   contact_type  clp_data, ax_x_data, ax_y_data, ax_z_data;
   logic         eul_valid, eul_ready;
   logic         clp_valid, clp_ready;
   logic         ax_x_valid, ax_x_ready;
   logic         ax_y_valid, ax_y_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower  <= {3{Q16_MIN}};
         cfg_ff.upper  <= {3{Q16_MAX}};
         cfg_ff.bounce <= '0;
         cfg_ff.tang   <= Q_ONE;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LOWER_X: cfg_ff.lower[0] <= csr_wdata;
            CSR_LOWER_Y: cfg_ff.lower[1] <= csr_wdata;
            CSR_LOWER_Z: cfg_ff.lower[2] <= csr_wdata;
            CSR_UPPER_X: cfg_ff.upper[0] <= csr_wdata;
            CSR_UPPER_Y: cfg_ff.upper[1] <= csr_wdata;
            CSR_UPPER_Z: cfg_ff.upper[2] <= csr_wdata;
            CSR_BOUNCE:  cfg_ff.bounce   <= clamp_factor(csr_wdata[16:0]);
            // keep one minus friction, the factor actually applied
            CSR_DRAG:    cfg_ff.tang     <= Q_ONE - clamp_factor(csr_wdata[16:0]);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_data.pos = req_tdata[95:0];
      req_data.vel = req_tdata[191:96];
      req_data.acc = req_tdata[287:192];
      req_data.dt  = req_tdata[303:288];
   end

   pec_euler u_euler (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_data),
      .out_valid (eul_valid),
      .out_ready (eul_ready),
      .out_data  (eul_data)
   );

   pec_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .lower     (cfg_ff.lower),
      .upper     (cfg_ff.upper),
      .in_valid  (eul_valid),
      .in_ready  (eul_ready),
      .in_data   (eul_data),
      .out_valid (clp_valid),
      .out_ready (clp_ready),
      .out_data  (clp_data)
   );

   pec_axis u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .axis_sel  (AXIS_X),
      .bounce    (cfg_ff.bounce),
      .tang      (cfg_ff.tang),
      .in_valid  (clp_valid),
      .in_ready  (clp_ready),
      .in_data   (clp_data),
      .out_valid (ax_x_valid),
      .out_ready (ax_x_ready),
      .out_data  (ax_x_data)
   );

   pec_axis u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .axis_sel  (AXIS_Y),
      .bounce    (cfg_ff.bounce),
      .tang      (cfg_ff.tang),
      .in_valid  (ax_x_valid),
      .in_ready  (ax_x_ready),
      .in_data   (ax_x_data),
      .out_valid (ax_y_valid),
      .out_ready (ax_y_ready),
      .out_data  (ax_y_data)
   );

   pec_axis u_axis_z (
      .clock     (clock),
      .reset     (reset),
      .axis_sel  (AXIS_Z),
      .bounce    (cfg_ff.bounce),
      .tang      (cfg_ff.tang),
      .in_valid  (ax_y_valid),
      .in_ready  (ax_y_ready),
      .in_data   (ax_y_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (ax_z_data)
   );

   assign rsp_tdata = {5'd0, ax_z_data.lo | ax_z_data.hi, ax_z_data.vel, ax_z_data.pos};

endmodule
